[rtl/smsrch_pkg.sv]
// shared constants and types for the submatrix search block
package smsrch_pkg;

    localparam int MAX_PAT_ROWS = 8;
    localparam int MAX_PAT_COLS = 8;
    localparam int MAX_TGT_ROWS = 16;
    localparam int MAX_TGT_COLS = 16;

    localparam int PAT_DEPTH = MAX_PAT_ROWS * MAX_PAT_COLS;
    localparam int TGT_DEPTH = MAX_TGT_ROWS * MAX_TGT_COLS;
    localparam int PAT_AW    = (PAT_DEPTH > 1) ? $clog2(PAT_DEPTH) : 1;
    localparam int TGT_AW    = (TGT_DEPTH > 1) ? $clog2(TGT_DEPTH) : 1;

    localparam int PR_W = (MAX_PAT_ROWS > 1) ? $clog2(MAX_PAT_ROWS) : 1;
    localparam int PC_W = (MAX_PAT_COLS > 1) ? $clog2(MAX_PAT_COLS) : 1;
    localparam int TR_W = (MAX_TGT_ROWS > 1) ? $clog2(MAX_TGT_ROWS) : 1;
    localparam int TC_W = (MAX_TGT_COLS > 1) ? $clog2(MAX_TGT_COLS) : 1;

    localparam int IDX_W      = 4;
    localparam int VAL_W      = 32;
    localparam int PSZ_W      = 4;
    localparam int TSZ_W      = 5;
    localparam int REQ_W      = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 8;

    typedef enum logic [REQ_W-1:0] {
        REQ_PAT    = 2'd0,
        REQ_TGT    = 2'd1,
        REQ_SEARCH = 2'd2
    } req_t;

    localparam logic [CFG_IDX_W-1:0] CFG_PAT_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_COLS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TGT_ROWS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TGT_COLS = 2'd3;

    typedef struct packed {
        logic              pat_we;
        logic              tgt_we;
        logic [PAT_AW-1:0] pat_waddr;
        logic [TGT_AW-1:0] tgt_waddr;
        logic [VAL_W-1:0]  wdata;
        logic              rd_en;
        logic [PAT_AW-1:0] pat_raddr;
        logic [TGT_AW-1:0] tgt_raddr;
    } mem_ctl_t;

endpackage

[rtl/submatrix_search.sv]
// top level of the two-dimensional pattern search block
//
// channel   dir  word                                  handshake
// s_        in   tuser: req_type; tdata: row,col,value  s_tvalid/s_tready
// m_        out  tdata: found                          m_tvalid/m_tready
// cfg_      in   index, wdata                          cfg_we, no wait
//
// a load word is written as it is accepted; a search compares one element pair
// at a time, set by the single memory read port pair and the one shared 32-bit
// comparator, and a mismatch ends a placement
// at once; reset clears control and sizes only, memories are not cleared;
// a result waiting on m_tready does not block loads, but the next search
// holds in its last cycle with s_tready low until that result drains
module submatrix_search (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_we,
    input  logic [smsrch_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [smsrch_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [smsrch_pkg::S_TDATA_W-1:0]      s_tdata,   // row, col, value
    input  logic [smsrch_pkg::REQ_W-1:0]          s_tuser,   // req_type
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [smsrch_pkg::M_TDATA_W-1:0]      m_tdata    // found
);
    import smsrch_pkg::*;

    mem_ctl_t          ctl;
    logic              eq;
    logic              found;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic [VAL_W-1:0]  value;

    assign row     = s_tdata[IDX_W-1:0];
    assign col     = s_tdata[2*IDX_W-1:IDX_W];
    assign value   = s_tdata[2*IDX_W+VAL_W-1:2*IDX_W];
    assign m_tdata = {{(M_TDATA_W-1){1'b0}}, found};

    smsrch_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .req       (s_tuser),
        .row       (row),
        .col       (col),
        .value     (value),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_found   (found),
        .ctl       (ctl),
        .eq        (eq)
    );

    smsrch_store u_store (
        .aclk (aclk),
        .ctl  (ctl),
        .eq   (eq)
    );

endmodule

[rtl/smsrch_store.sv]
// pattern and target memories with registered reads and the shared word compare
module smsrch_store (
    input  logic                 aclk,
    input  smsrch_pkg::mem_ctl_t ctl,
    output logic                 eq
);
    import smsrch_pkg::*;

    logic [VAL_W-1:0] pat_mem [PAT_DEPTH];
    logic [VAL_W-1:0] tgt_mem [TGT_DEPTH];
    logic [VAL_W-1:0] pat_q_reg;
    logic [VAL_W-1:0] tgt_q_reg;

    always_ff @(posedge aclk) begin
        if (ctl.pat_we) begin
            pat_mem[ctl.pat_waddr] <= ctl.wdata;
        end
        if (ctl.rd_en) begin
            pat_q_reg <= pat_mem[ctl.pat_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.tgt_we) begin
            tgt_mem[ctl.tgt_waddr] <= ctl.wdata;
        end
        if (ctl.rd_en) begin
            tgt_q_reg <= tgt_mem[ctl.tgt_raddr];
        end
    end

    assign eq = (pat_q_reg == tgt_q_reg);

endmodule

[rtl/smsrch_seq.sv]
// size registers, placement and element counters, and the search sequencer
module smsrch_seq (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [smsrch_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [smsrch_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [smsrch_pkg::REQ_W-1:0]        req,
    input  logic [smsrch_pkg::IDX_W-1:0]        row,
    input  logic [smsrch_pkg::IDX_W-1:0]        col,
    input  logic [smsrch_pkg::VAL_W-1:0]        value,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic                                m_found,
    output smsrch_pkg::mem_ctl_t                ctl,
    input  logic                                eq
);
    import smsrch_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_COMP,
        ST_FIN
    } state_t;

    state_t            state_reg;
    logic [PSZ_W-1:0]  pat_rows_reg;
    logic [PSZ_W-1:0]  pat_cols_reg;
    logic [TSZ_W-1:0]  tgt_rows_reg;
    logic [TSZ_W-1:0]  tgt_cols_reg;
    logic [TR_W-1:0]   r0_reg;
    logic [TC_W-1:0]   c0_reg;
    logic [PR_W-1:0]   r_reg;
    logic [PC_W-1:0]   c_reg;
    logic              found_reg;
    logic              m_found_reg;
    logic              m_valid_reg;

    logic [PSZ_W-1:0]  pr;
    logic [PSZ_W-1:0]  pc;
    logic [TSZ_W-1:0]  tr;
    logic [TSZ_W-1:0]  tc;
    logic              no_fit;
    logic              last_c;
    logic              last_r;
    logic              last_c0;
    logic              last_r0;
    logic              in_acc;

    // size clamping: zero reads as one, above maximum reads as maximum
    always_comb begin
        if (pat_rows_reg == '0) begin
            pr = PSZ_W'(1);
        end else if (int'(pat_rows_reg) > MAX_PAT_ROWS) begin
            pr = PSZ_W'(MAX_PAT_ROWS);
        end else begin
            pr = pat_rows_reg;
        end
        if (pat_cols_reg == '0) begin
            pc = PSZ_W'(1);
        end else if (int'(pat_cols_reg) > MAX_PAT_COLS) begin
            pc = PSZ_W'(MAX_PAT_COLS);
        end else begin
            pc = pat_cols_reg;
        end
        if (tgt_rows_reg == '0) begin
            tr = TSZ_W'(1);
        end else if (int'(tgt_rows_reg) > MAX_TGT_ROWS) begin
            tr = TSZ_W'(MAX_TGT_ROWS);
        end else begin
            tr = tgt_rows_reg;
        end
        if (tgt_cols_reg == '0) begin
            tc = TSZ_W'(1);
        end else if (int'(tgt_cols_reg) > MAX_TGT_COLS) begin
            tc = TSZ_W'(MAX_TGT_COLS);
        end else begin
            tc = tgt_cols_reg;
        end
    end

    assign no_fit  = (TSZ_W'(pr) > tr) || (TSZ_W'(pc) > tc);
    assign last_c  = (PSZ_W'(c_reg) + PSZ_W'(1)) == pc;
    assign last_r  = (PSZ_W'(r_reg) + PSZ_W'(1)) == pr;
    assign last_c0 = (TSZ_W'(c0_reg) + TSZ_W'(pc)) == tc;
    assign last_r0 = (TSZ_W'(r0_reg) + TSZ_W'(pr)) == tr;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_found  = m_found_reg;

    always_comb begin
        ctl.pat_we    = in_acc && (req == REQ_PAT) &&
                        (int'(row) < MAX_PAT_ROWS) && (int'(col) < MAX_PAT_COLS);
        ctl.tgt_we    = in_acc && (req == REQ_TGT) &&
                        (int'(row) < MAX_TGT_ROWS) && (int'(col) < MAX_TGT_COLS);
        ctl.pat_waddr = PAT_AW'(int'(row) * MAX_PAT_COLS + int'(col));
        ctl.tgt_waddr = TGT_AW'(int'(row) * MAX_TGT_COLS + int'(col));
        ctl.wdata     = value;
        ctl.rd_en     = (state_reg == ST_READ);
        ctl.pat_raddr = PAT_AW'(int'(r_reg) * MAX_PAT_COLS + int'(c_reg));
        ctl.tgt_raddr = TGT_AW'((int'(r0_reg) + int'(r_reg)) * MAX_TGT_COLS
                                + int'(c0_reg) + int'(c_reg));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_valid_reg  <= 1'b0;
            pat_rows_reg <= PSZ_W'(1);
            pat_cols_reg <= PSZ_W'(1);
            tgt_rows_reg <= TSZ_W'(16);
            tgt_cols_reg <= TSZ_W'(16);
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_PAT_ROWS: pat_rows_reg <= cfg_wdata[PSZ_W-1:0];
                    CFG_PAT_COLS: pat_cols_reg <= cfg_wdata[PSZ_W-1:0];
                    CFG_TGT_ROWS: tgt_rows_reg <= cfg_wdata[TSZ_W-1:0];
                    CFG_TGT_COLS: tgt_cols_reg <= cfg_wdata[TSZ_W-1:0];
                endcase
            end
            if (m_valid_reg && m_tready && (state_reg != ST_FIN)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid && (req == REQ_SEARCH)) begin
                        r0_reg <= '0;
                        c0_reg <= '0;
                        r_reg  <= '0;
                        c_reg  <= '0;
                        if (no_fit) begin
                            found_reg <= 1'b0;
                            state_reg <= ST_FIN;
                        end else begin
                            state_reg <= ST_READ;
                        end
                    end
                end
                ST_READ: begin
                    state_reg <= ST_COMP;
                end
                ST_COMP: begin
                    if (!eq) begin
                        if (last_c0 && last_r0) begin
                            found_reg <= 1'b0;
                            state_reg <= ST_FIN;
                        end else begin
                            // next placement, row by row
                            r_reg <= '0;
                            c_reg <= '0;
                            if (last_c0) begin
                                c0_reg <= '0;
                                r0_reg <= r0_reg + TR_W'(1);
                            end else begin
                                c0_reg <= c0_reg + TC_W'(1);
                            end
                            state_reg <= ST_READ;
                        end
                    end else if (last_c && last_r) begin
                        found_reg <= 1'b1;
                        state_reg <= ST_FIN;
                    end else begin
                        if (last_c) begin
                            c_reg <= '0;
                            r_reg <= r_reg + PR_W'(1);
                        end else begin
                            c_reg <= c_reg + PC_W'(1);
                        end
                        state_reg <= ST_READ;
                    end
                end
                ST_FIN: begin
                    if (!m_valid_reg || m_tready) begin
                        m_valid_reg <= 1'b1;
                        m_found_reg <= found_reg;
                        state_reg   <= ST_IDLE;
                    end
                end
            endcase
        end
    end

endmodule

[rtl/smsrch_check.sv]
// port checker for the submatrix search block and its bind
module smsrch_check (
    input logic                                  aclk,
    input logic                                  aresetn,
    input logic                                  s_tvalid,
    input logic                                  s_tready,
    input logic [smsrch_pkg::REQ_W-1:0]          s_tuser,
    input logic                                  m_tvalid,
    input logic                                  m_tready,
    input logic [smsrch_pkg::M_TDATA_W-1:0]      m_tdata
);
    import smsrch_pkg::*;

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // a search word takes the block busy on the next cycle
    a_search_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == REQ_SEARCH) |=> !s_tready)
        else $error("ready after search word");

    // after a load word the block is ready again on the next cycle
    a_load_one: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser != REQ_SEARCH) |=> s_tready)
        else $error("load word did not finish in one cycle");

    // only the found bit may be set
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[M_TDATA_W-1:1] == '0))
        else $error("result padding not zero");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("not idle after reset");

endmodule

bind submatrix_search smsrch_check u_check (.*);

[dv/tb_submatrix_search.sv]
// testbench for submatrix_search: directed and random load/search words checked against a predictor
`timescale 1ns / 100ps

module tb_submatrix_search;
    import smsrch_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int unsigned RUN_LIMIT   = 2_000_000;
    localparam int unsigned HOLD_CYCLES = 2000;
    localparam int unsigned TOTAL_WORDS = 500;

    typedef struct packed {
        logic [REQ_W-1:0] kind;
        logic [3:0]       row;
        logic [3:0]       col;
        logic [31:0]      val;
        logic             typed;
        logic             want;
    } dir_row_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;   // row, col, value
    logic [REQ_W-1:0]      s_tuser   = '0;   // req_type
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;          // found

    logic [31:0] pat_img [PAT_DEPTH];
    logic [31:0] tgt_img [TGT_DEPTH];
    logic [3:0]  pat_rows_reg = 4'd1;
    logic [3:0]  pat_cols_reg = 4'd1;
    logic [4:0]  tgt_rows_reg = 5'd16;
    logic [4:0]  tgt_cols_reg = 5'd16;

    bit          pending_found [$];
    bit          want_found;
    int unsigned errors       = 0;
    int unsigned cycle_count  = 0;
    int unsigned sent_words   = 0;
    bit          gaps_on      = 1'b1;
    int unsigned hold_asked   = 0;
    int unsigned hold_done    = 0;

    dir_row_t dir_rows [18] = '{
        '{REQ_PAT,    4'd0,  4'd0,  32'h8000_0000, 1'b0, 1'b0},
        '{REQ_SEARCH, 4'd0,  4'd0,  32'h0000_0000, 1'b1, 1'b0},
        '{REQ_TGT,    4'd15, 4'd15, 32'h8000_0000, 1'b0, 1'b0},
        '{REQ_SEARCH, 4'd0,  4'd0,  32'h0000_0000, 1'b1, 1'b1},
        '{REQ_PAT,    4'd0,  4'd0,  32'h7fff_ffff, 1'b0, 1'b0},
        '{REQ_SEARCH, 4'd15, 4'd15, 32'hffff_ffff, 1'b1, 1'b0},
        '{REQ_TGT,    4'd0,  4'd0,  32'h7fff_ffff, 1'b0, 1'b0},
        '{REQ_SEARCH, 4'd0,  4'd0,  32'h0000_0000, 1'b1, 1'b1},
        '{REQ_PAT,    4'd8,  4'd0,  32'h0000_0005, 1'b0, 1'b0},
        '{REQ_PAT,    4'd0,  4'd8,  32'h0000_0005, 1'b0, 1'b0},
        '{REQ_PAT,    4'd15, 4'd15, 32'h0000_0005, 1'b0, 1'b0},
        '{REQ_SEARCH, 4'd0,  4'd0,  32'h0000_0000, 1'b1, 1'b1},
        '{REQ_UNUSED, 4'd0,  4'd0,  32'h0000_0005, 1'b0, 1'b0},
        '{REQ_SEARCH, 4'd0,  4'd0,  32'h0000_0000, 1'b1, 1'b1},
        '{REQ_PAT,    4'd0,  4'd0,  32'hffff_ffff, 1'b0, 1'b0},
        '{REQ_SEARCH, 4'd0,  4'd0,  32'h0000_0000, 1'b1, 1'b0},
        '{REQ_TGT,    4'd7,  4'd9,  32'hffff_ffff, 1'b0, 1'b0},
        '{REQ_SEARCH, 4'd0,  4'd0,  32'h0000_0000, 1'b1, 1'b1}
    };

    logic [19:0] corner_sizes [6] = '{
        {5'd1,  5'd1,  5'd1,  5'd1},
        {5'd0,  5'd0,  5'd0,  5'd0},
        {5'd15, 5'd15, 5'd31, 5'd31},
        {5'd24, 5'd8,  5'd4,  5'd16},
        {5'd4,  5'd4,  5'd4,  5'd4},
        {5'd2,  5'd8,  5'd16, 5'd1}
    };

    submatrix_search dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #4 aclk = ~aclk;

    function automatic int eff_size(input int v, input int maxv);
        if (v == 0) return 1;
        if (v > maxv) return maxv;
        return v;
    endfunction

    function automatic bit pattern_found();
        int pr, pc, tr, tc;
        bit hit;
        pr = eff_size(int'(pat_rows_reg), MAX_PAT_ROWS);
        pc = eff_size(int'(pat_cols_reg), MAX_PAT_COLS);
        tr = eff_size(int'(tgt_rows_reg), MAX_TGT_ROWS);
        tc = eff_size(int'(tgt_cols_reg), MAX_TGT_COLS);
        if (pr > tr || pc > tc) return 1'b0;
        for (int r0 = 0; r0 + pr <= tr; r0++) begin
            for (int c0 = 0; c0 + pc <= tc; c0++) begin
                hit = 1'b1;
                for (int r = 0; r < pr; r++) begin
                    for (int c = 0; c < pc; c++) begin
                        if (pat_img[PAT_AW'(r * MAX_PAT_COLS + c)] !=
                            tgt_img[TGT_AW'((r0 + r) * MAX_TGT_COLS + c0 + c)]) hit = 1'b0;
                    end
                end
                if (hit) return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 4))
            0, 1: return $urandom_range(0, 2);
            2:    return $urandom();
            3:    return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
            default: return 32'hffff_ffff;
        endcase
    endfunction

    task automatic send_word(input logic [REQ_W-1:0] kind, input logic [3:0] row,
                             input logic [3:0] col, input logic [31:0] val,
                             input bit typed = 1'b0, input bit want = 1'b0);
        int unsigned gap;
        gap = gaps_on ? pick_gap() : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {val, col, row};
        do @(posedge aclk); while (s_tready !== 1'b1);
        case (kind)
            REQ_PAT: begin
                if (int'(row) < MAX_PAT_ROWS && int'(col) < MAX_PAT_COLS)
                    pat_img[PAT_AW'(int'(row) * MAX_PAT_COLS + int'(col))] = val;
            end
            REQ_TGT: begin
                if (int'(row) < MAX_TGT_ROWS && int'(col) < MAX_TGT_COLS)
                    tgt_img[TGT_AW'(int'(row) * MAX_TGT_COLS + int'(col))] = val;
            end
            REQ_SEARCH: pending_found.push_back(typed ? want : pattern_found());
            default: ;
        endcase
        if (kind != REQ_UNUSED) sent_words++;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_found.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic set_sizes(input logic [4:0] pr, input logic [4:0] pc,
                             input logic [4:0] tr, input logic [4:0] tc);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_PAT_ROWS;
        cfg_wdata <= pr;
        @(posedge aclk);
        cfg_index <= CFG_PAT_COLS;
        cfg_wdata <= pc;
        @(posedge aclk);
        cfg_index <= CFG_TGT_ROWS;
        cfg_wdata <= tr;
        @(posedge aclk);
        cfg_index <= CFG_TGT_COLS;
        cfg_wdata <= tc;
        @(posedge aclk);
        cfg_we <= 1'b0;
        pat_rows_reg = pr[3:0];
        pat_cols_reg = pc[3:0];
        tgt_rows_reg = tr;
        tgt_cols_reg = tc;
    endtask

    // load a pattern, sprinkle the target, often plant the pattern, then search
    task automatic run_match_seq();
        int pr, pc, tr, tc, r0, c0;
        logic [31:0] v;
        pr = eff_size(int'(pat_rows_reg), MAX_PAT_ROWS);
        pc = eff_size(int'(pat_cols_reg), MAX_PAT_COLS);
        tr = eff_size(int'(tgt_rows_reg), MAX_TGT_ROWS);
        tc = eff_size(int'(tgt_cols_reg), MAX_TGT_COLS);
        for (int r = 0; r < pr; r++) begin
            for (int c = 0; c < pc; c++) begin
                if ($urandom_range(0, 1)) send_word(REQ_PAT, 4'(r), 4'(c), pick_value());
            end
        end
        repeat ($urandom_range(0, 4))
            send_word(REQ_TGT, 4'($urandom_range(0, tr - 1)), 4'($urandom_range(0, tc - 1)),
                      pick_value());
        if (pr <= tr && pc <= tc && $urandom_range(0, 3) != 0) begin
            r0 = $urandom_range(0, tr - pr);
            c0 = $urandom_range(0, tc - pc);
            for (int r = 0; r < pr; r++) begin
                for (int c = 0; c < pc; c++) begin
                    v = pat_img[PAT_AW'(r * MAX_PAT_COLS + c)];
                    if ($urandom_range(0, 9) == 0) v ^= 32'd1 << $urandom_range(0, 31);
                    send_word(REQ_TGT, 4'(r0 + r), 4'(c0 + c), v);
                end
            end
        end
        send_word(REQ_SEARCH, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                  $urandom());
    endtask

    task automatic send_noise();
        logic [REQ_W-1:0] kind;
        case ($urandom_range(0, 9))
            0:       kind = REQ_UNUSED;
            1, 2:    kind = REQ_SEARCH;
            3, 4, 5: kind = REQ_PAT;
            default: kind = REQ_TGT;
        endcase
        send_word(kind, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)), pick_value());
    endtask

    initial begin : stimulus
        int unsigned phase;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int r = 0; r < MAX_PAT_ROWS; r++)
            for (int c = 0; c < MAX_PAT_COLS; c++) send_word(REQ_PAT, 4'(r), 4'(c), 32'd0);
        for (int r = 0; r < MAX_TGT_ROWS; r++)
            for (int c = 0; c < MAX_TGT_COLS; c++) send_word(REQ_TGT, 4'(r), 4'(c), 32'd0);

        foreach (dir_rows[i])
            send_word(dir_rows[i].kind, dir_rows[i].row, dir_rows[i].col, dir_rows[i].val,
                      dir_rows[i].typed, dir_rows[i].want);

        foreach (corner_sizes[i]) begin
            wait_idle();
            set_sizes(corner_sizes[i][19:15], corner_sizes[i][14:10],
                      corner_sizes[i][9:5], corner_sizes[i][4:0]);
            run_match_seq();
        end

        phase = 0;
        while (sent_words < TOTAL_WORDS || phase < 3) begin
            wait_idle();
            if ($urandom_range(0, 99) < 80)
                set_sizes(5'($urandom_range(1, 3)), 5'($urandom_range(1, 3)),
                          5'($urandom_range(1, 8)), 5'($urandom_range(1, 8)));
            else
                set_sizes(5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                          5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)));
            gaps_on = (phase % 3 != 1);
            if (phase == 2) begin
                hold_asked++;
                gaps_on = 1'b0;
                wait (hold_done == hold_asked);
                repeat (6) run_match_seq();
            end
            repeat ($urandom_range(2, 6)) begin
                if ($urandom_range(0, 3) != 0) run_match_seq();
                else repeat ($urandom_range(1, 4)) send_noise();
            end
            phase++;
        end

        wait_idle();
        repeat (200) @(posedge aclk);
        if (errors == 0) begin
            $display("[submatrix_search] OK");
        end else begin
            $display("[submatrix_search] ERROR");
        end
        $finish;
    end

    initial begin : result_sink
        int unsigned gap;
        forever begin
            @(posedge aclk);
            if (hold_asked != hold_done) begin
                hold_done++;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_tready <= 1'b1;
            if ($urandom_range(0, 7) == 0) repeat ($urandom_range(50, 200)) @(posedge aclk);
            else repeat ($urandom_range(1, 12)) @(posedge aclk);
            gap = pick_gap();
            if (gap != 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid === 1'b1 && m_tready === 1'b1) begin
            if (pending_found.size() == 0) begin
                $error("result word with nothing expected: found actual %0b", m_tdata[0]);
                errors++;
            end else begin
                want_found = pending_found.pop_front();
                if (m_tdata[0] !== want_found) begin
                    $error("found: expected %0b actual %0b", want_found, m_tdata[0]);
                    errors++;
                end
                if (m_tdata[M_TDATA_W-1:1] !== '0) begin
                    $error("m_tdata pad: expected 0 actual %0h", m_tdata[M_TDATA_W-1:1]);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == RUN_LIMIT) begin
            $display("[submatrix_search] ERROR");
            $finish;
        end
    end

endmodule
